[rtl/abae_pkg.sv]
// Shared types and constants of the adaptive binary arithmetic encoder.
`default_nettype none
package abae_pkg;
    localparam int CNT_W        = 16;
    localparam int RANGE_W      = 17;
    localparam int PEND_W       = 9;
    localparam int PEND_MAX_DEF = 480;
    localparam int OCNT_W       = 7;
    localparam int MAX_OUT      = 64;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RESCALE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ZERO     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TOTAL    = 2'd2;

    localparam logic [CNT_W-1:0] RESCALE_LIMIT_RST = 16'd20;
    localparam logic [CNT_W-1:0] INIT_ZERO_RST     = 16'd1;
    localparam logic [CNT_W-1:0] INIT_TOTAL_RST    = 16'd11;
    localparam logic [CNT_W-1:0] RANGE_TOP         = 16'hffff;
    localparam logic [CNT_W-1:0] ZERO_MAX          = 16'hfffe;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quo;
    } t_md_out;
endpackage
`default_nettype wire

[rtl/abae_muldiv.sv]
// Bit-serial multiply then divide: quo = range * zc / tc (quotient below 2^16).
`default_nettype none
module abae_muldiv
    import abae_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [RANGE_W-1:0] i_range,
    input  wire logic [CNT_W-1:0]   i_zc,
    input  wire logic [CNT_W-1:0]   i_tc,
    output t_md_out                 o_res
);
    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} t_md_state;

    t_md_state                r_st;
    logic [2*CNT_W:0]         r_acc;
    logic [RANGE_W-1:0]       r_mcand;
    logic [CNT_W-1:0]         r_mplier;
    logic [CNT_W-1:0]         r_div;
    logic [CNT_W-1:0]         r_rem;
    logic [3:0]               r_cnt;
    logic                     r_done;

    logic [2*CNT_W:0]         w_addend;
    logic [2*CNT_W:0]         w_prod;
    logic [CNT_W:0]           w_shift;
    logic                     w_ge;

    assign w_addend = r_mplier[CNT_W-1] ? {{CNT_W{1'b0}}, r_mcand} : '0;
    assign w_prod   = {r_acc[2*CNT_W-1:0], 1'b0} + w_addend;
    assign w_shift  = {r_rem, r_acc[CNT_W-1]};
    assign w_ge     = w_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= MD_IDLE;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                MD_IDLE: begin
                    if (i_start) begin
                        r_acc    <= '0;
                        r_mcand  <= i_range;
                        r_mplier <= i_zc;
                        r_div    <= i_tc;
                        r_cnt    <= '0;
                        r_st     <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    r_acc    <= w_prod;
                    r_mplier <= {r_mplier[CNT_W-2:0], 1'b0};
                    r_cnt    <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        // last product step seeds the remainder with the upper half
                        r_rem <= w_prod[2*CNT_W-1:CNT_W];
                        r_st  <= MD_DIV;
                    end
                end
                MD_DIV: begin
                    r_rem <= w_ge ? CNT_W'(w_shift - {1'b0, r_div}) : w_shift[CNT_W-1:0];
                    r_acc[CNT_W-1:0] <= {r_acc[CNT_W-2:0], w_ge};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_st   <= MD_IDLE;
                        r_done <= 1'b1;
                    end
                end
                default: r_st <= MD_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_acc[CNT_W-1:0];
endmodule
`default_nettype wire

[rtl/adaptive_binary_arith_encoder_top.sv]
// Top level of the adaptive binary arithmetic encoder.
`default_nettype none
// One binary symbol per transaction is coded into a 16-bit arithmetic-code
// interval with an adaptive zero/total count model; emitted code bits are
// packed MSB first and leave as bytes, one byte per output transaction.
// run_last marks the last byte caused by an input, stream_last the final
// byte of a flushed stream (end_of_stream set). Items are handled one at a
// time: the split point range*zero/total comes from a bit-serial unit that
// multiplies and then divides, and renormalization shifts one interval bit
// or one pending bit per cycle while the output side does not stall it. A
// flush pads the last byte with zero bits. The initial counts take effect
// at the next stream start, the rescale limit at the next model update. At
// most 64 bytes are delivered per input; extra bytes of that input are
// dropped.
module adaptive_binary_arith_encoder_top
    import abae_pkg::*;
#(
    parameter int PENDING_MAX = PEND_MAX_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_symbol,
    input  wire logic                 i_end_of_stream,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [7:0]                o_code_byte,
    output logic                      o_run_last,
    output logic                      o_stream_last,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CNT_W-1:0]     i_cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_START, S_CALC, S_APPLY, S_RENORM, S_PEND, S_PAD, S_FINISH
    } t_state;

    // configuration
    logic [CNT_W-1:0]   r_limit, r_init_z, r_init_t;
    // coder state
    t_state             r_st, n_st;
    logic [CNT_W-1:0]   r_low, n_low, r_high, n_high;
    logic [PEND_W-1:0]  r_pend, n_pend;
    logic [CNT_W-1:0]   r_zc, n_zc, r_tc, n_tc;
    logic [7:0]         r_pack, n_pack;
    logic [2:0]         r_fill, n_fill;
    logic               r_sidle, n_sidle;
    logic               r_sym, n_sym, r_eos, n_eos, r_flush, n_flush, r_pbit, n_pbit;
    logic [RANGE_W-1:0] r_range, n_range;
    logic [OCNT_W-1:0]  r_cnt, n_cnt;
    // byte held back until it is known whether it is the last of the item
    logic               r_hold_v, n_hold_v;
    logic [7:0]         r_hold, n_hold;
    // output register
    logic               r_out_v, n_out_v, r_out_rl, n_out_rl, r_out_sl, n_out_sl;
    logic [7:0]         r_out_b, n_out_b;

    t_md_out            w_md;
    logic [RANGE_W-1:0] w_range;
    logic               w_diff, w_strad, w_bit_req, w_bit, w_full, w_room, w_out_free;
    logic               w_block;
    logic [CNT_W-1:0]   w_lz, w_lt;
    logic [RANGE_W-1:0] w_split;
    logic [CNT_W-1:0]   w_z1, w_z2, w_t2;
    logic [CNT_W:0]     w_t1;

    assign w_range = {1'b0, r_high} - {1'b0, r_low} + RANGE_W'(1);

    abae_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_st == S_START),
        .i_range (w_range),
        .i_zc    (r_zc),
        .i_tc    (r_tc),
        .o_res   (w_md)
    );

    // initial counts, made consistent
    always_comb begin
        w_lz = r_init_z;
        if (w_lz == '0) w_lz = CNT_W'(1);
        if (w_lz > ZERO_MAX) w_lz = ZERO_MAX;
        w_lt = (r_init_t <= w_lz) ? w_lz + CNT_W'(1) : r_init_t;
    end

    // split clamp and model update
    always_comb begin
        w_split = (w_md.quo == '0) ? RANGE_W'(1) : {1'b0, w_md.quo};
        if (w_split >= r_range) w_split = r_range - RANGE_W'(1);
        w_z1 = r_sym ? r_zc : r_zc + CNT_W'(1);
        w_t1 = {1'b0, r_tc} + (CNT_W+1)'(1);
        w_z2 = w_z1;
        w_t2 = w_t1[CNT_W-1:0];
        if (w_t1 > {1'b0, r_limit}) begin
            w_z2 = w_z1 >> 1;
            w_t2 = w_t1[CNT_W:1];
            if (w_z2 == '0) w_z2 = CNT_W'(1);
            if (w_z2 >= w_t2) w_t2 = w_z2 + CNT_W'(1);
        end
    end

    // bit emission and back-pressure
    assign w_diff     = r_high[CNT_W-1] ^ r_low[CNT_W-1];
    assign w_strad    = r_low[CNT_W-2] & ~r_high[CNT_W-2];
    assign w_bit_req  = (r_st == S_RENORM && !w_diff) || (r_st == S_PEND) ||
                        (r_st == S_PAD && r_fill != 3'd0);
    assign w_bit      = (r_st == S_RENORM) ? r_high[CNT_W-1] :
                        (r_st == S_PEND) ? r_pbit : 1'b0;
    assign w_full     = (r_fill == 3'd7);
    assign w_room     = (r_cnt < OCNT_W'(MAX_OUT));
    assign w_out_free = !r_out_v || !i_out_stall;
    assign w_block    = w_bit_req && w_full && w_room && r_hold_v && !w_out_free;

    always_comb begin
        n_st = r_st; n_low = r_low; n_high = r_high; n_pend = r_pend;
        n_zc = r_zc; n_tc = r_tc; n_pack = r_pack; n_fill = r_fill;
        n_sidle = r_sidle; n_sym = r_sym; n_eos = r_eos; n_flush = r_flush;
        n_pbit = r_pbit; n_range = r_range; n_cnt = r_cnt;
        n_hold_v = r_hold_v; n_hold = r_hold;
        n_out_v = r_out_v; n_out_b = r_out_b; n_out_rl = r_out_rl; n_out_sl = r_out_sl;

        if (r_out_v && !i_out_stall) n_out_v = 1'b0;

        if (w_bit_req && !w_block) begin
            n_pack = w_full ? 8'd0 : {r_pack[6:0], w_bit};
            n_fill = r_fill + 3'd1;
            if (w_full && w_room) begin
                if (r_hold_v) begin
                    n_out_v  = 1'b1;
                    n_out_b  = r_hold;
                    n_out_rl = 1'b0;
                    n_out_sl = 1'b0;
                end
                n_hold_v = 1'b1;
                n_hold   = {r_pack[6:0], w_bit};
                n_cnt    = r_cnt + OCNT_W'(1);
            end
        end

        case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sym   = i_symbol;
                    n_eos   = i_end_of_stream;
                    n_cnt   = '0;
                    n_flush = 1'b0;
                    if (r_sidle) begin
                        n_zc    = w_lz;
                        n_tc    = w_lt;
                        n_low   = '0;
                        n_high  = RANGE_TOP;
                        n_pend  = '0;
                        n_sidle = 1'b0;
                    end
                    n_st = S_START;
                end
            end
            S_START: begin
                n_range = w_range;
                n_st    = S_CALC;
            end
            S_CALC: begin
                if (w_md.done) n_st = S_APPLY;
            end
            S_APPLY: begin
                if (!r_sym) n_high = CNT_W'({1'b0, r_low} + w_split - RANGE_W'(1));
                else        n_low  = CNT_W'({1'b0, r_low} + w_split);
                n_zc = w_z2;
                n_tc = w_t2;
                n_st = S_RENORM;
            end
            S_RENORM: begin
                if (w_diff) begin
                    if (w_strad) begin
                        // underflow: expand around the midpoint
                        if (r_pend < PEND_W'(PENDING_MAX)) n_pend = r_pend + PEND_W'(1);
                        n_low  = {1'b0, r_low[CNT_W-3:0], 1'b0};
                        n_high = {1'b1, r_high[CNT_W-3:0], 1'b1};
                    end else if (r_eos && !r_flush) begin
                        n_low   = r_high;
                        n_flush = 1'b1;
                    end else if (r_flush) begin
                        n_st = S_PAD;
                    end else begin
                        n_st = S_FINISH;
                    end
                end else if (!w_block) begin
                    n_low  = {r_low[CNT_W-2:0], 1'b0};
                    n_high = {r_high[CNT_W-2:0], 1'b1};
                    if (r_pend != '0) begin
                        n_pbit = ~r_high[CNT_W-1];
                        n_st   = S_PEND;
                    end
                end
            end
            S_PEND: begin
                if (!w_block) begin
                    n_pend = r_pend - PEND_W'(1);
                    if (r_pend == PEND_W'(1)) n_st = S_RENORM;
                end
            end
            S_PAD: begin
                if (r_fill == 3'd0) begin
                    n_low   = '0;
                    n_high  = RANGE_TOP;
                    n_pend  = '0;
                    n_sidle = 1'b1;
                    n_st    = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_hold_v) begin
                    n_st = S_IDLE;
                end else if (w_out_free) begin
                    n_out_v  = 1'b1;
                    n_out_b  = r_hold;
                    n_out_rl = 1'b1;
                    n_out_sl = r_eos;
                    n_hold_v = 1'b0;
                    n_st     = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= RESCALE_LIMIT_RST;
            r_init_z <= INIT_ZERO_RST;
            r_init_t <= INIT_TOTAL_RST;
            r_st     <= S_IDLE;
            r_low    <= '0;
            r_high   <= RANGE_TOP;
            r_pend   <= '0;
            r_zc     <= INIT_ZERO_RST;
            r_tc     <= INIT_TOTAL_RST;
            r_pack   <= '0;
            r_fill   <= '0;
            r_sidle  <= 1'b1;
            r_flush  <= 1'b0;
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RESCALE_LIMIT: r_limit  <= i_cfg_data;
                    CFG_INIT_ZERO:     r_init_z <= i_cfg_data;
                    CFG_INIT_TOTAL:    r_init_t <= i_cfg_data;
                    default: ;
                endcase
            end
            r_st     <= n_st;
            r_low    <= n_low;
            r_high   <= n_high;
            r_pend   <= n_pend;
            r_zc     <= n_zc;
            r_tc     <= n_tc;
            r_pack   <= n_pack;
            r_fill   <= n_fill;
            r_sidle  <= n_sidle;
            r_flush  <= n_flush;
            r_cnt    <= n_cnt;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
        r_sym    <= n_sym;
        r_eos    <= n_eos;
        r_pbit   <= n_pbit;
        r_range  <= n_range;
        r_hold   <= n_hold;
        r_out_b  <= n_out_b;
        r_out_rl <= n_out_rl;
        r_out_sl <= n_out_sl;
    end

    assign o_in_stall    = (r_st != S_IDLE);
    assign o_out_valid   = r_out_v;
    assign o_code_byte   = r_out_b;
    assign o_run_last    = r_out_rl;
    assign o_stream_last = r_out_sl;

`ifndef SYNTHESIS
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= OCNT_W'(MAX_OUT)) else $error("byte count beyond cap");
    a_pend_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(PENDING_MAX)) else $error("pending count beyond limit");
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_IDLE |-> !r_hold_v) else $error("held byte left at idle");
    a_stream_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_sl |-> r_out_rl) else $error("stream end without run end");
`endif
endmodule
`default_nettype wire

[tb/abae_checker.sv]
// Checker for the adaptive binary arithmetic encoder: predicts and compares output bytes.
module abae_checker
    import abae_pkg::*;
#(
    parameter int PENDING_MAX = PEND_MAX_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic                 i_symbol,
    input  wire logic                 i_end_of_stream,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [7:0]           i_code_byte,
    input  wire logic                 i_run_last,
    input  wire logic                 i_stream_last,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CNT_W-1:0]     i_cfg_data,
    output int                        o_errors,
    output int                        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       run_last;
        logic       stream_last;
    } t_code_out;

    t_code_out        code_q[$];
    t_code_out        fresh_q[$];

    logic [CNT_W-1:0] rescale_limit, init_zero, init_total;
    logic [CNT_W-1:0] lo, hi, zero_cnt, total_cnt;
    logic [PEND_W-1:0] pend;
    logic [7:0]       pack;
    logic [2:0]       fill;
    logic             stream_idle;
    int               errors;

    assign o_errors      = errors;
    assign o_outstanding = code_q.size();

    // shift one code bit into the byte packer; full bytes beyond MAX_OUT are dropped
    function automatic void pack_bit(logic b);
        t_code_out c;
        pack = {pack[6:0], b};
        fill = fill + 3'd1;
        if (fill == 3'd0) begin
            if (fresh_q.size() < MAX_OUT) begin
                c = '{code_byte: pack, run_last: 1'b0, stream_last: 1'b0};
                fresh_q.push_back(c);
            end
            pack = '0;
        end
    endfunction

    function automatic void renorm();
        logic b;
        while (1) begin
            if (hi[15] != lo[15]) begin
                // straddling the middle: expand and count an underflow bit
                if (lo[14] && !hi[14]) begin
                    if (pend < PENDING_MAX) pend = pend + 1'b1;
                    lo = lo & 16'h3fff;
                    hi = hi | 16'h4000;
                end else begin
                    break;
                end
            end else begin
                b = hi[15];
                pack_bit(b);
                while (pend != 0) begin
                    pack_bit(!b);
                    pend = pend - 1'b1;
                end
            end
            lo = {lo[14:0], 1'b0};
            hi = {hi[14:0], 1'b1};
        end
    endfunction

    function automatic void encode_symbol(logic sym, logic eos);
        logic [RANGE_W-1:0] rng;
        logic [32:0]        split;
        logic [CNT_W:0]     tot17;
        logic [CNT_W-1:0]   z;
        fresh_q.delete();
        if (stream_idle) begin
            z = (init_zero == 0) ? 16'd1 : init_zero;
            if (z > ZERO_MAX) z = ZERO_MAX;
            zero_cnt  = z;
            total_cnt = (init_total <= z) ? z + 16'd1 : init_total;
            lo = '0;
            hi = RANGE_TOP;
            pend = '0;
            stream_idle = 1'b0;
        end
        rng   = {1'b0, hi} - {1'b0, lo} + 17'd1;
        split = (33'(rng) * 33'(zero_cnt)) / 33'(total_cnt);
        if (split == 0) split = 33'd1;
        if (split >= 33'(rng)) split = 33'(rng) - 33'd1;
        if (!sym) hi = lo + split[15:0] - 16'd1;
        else      lo = lo + split[15:0];
        renorm();

        // adaptive model update with halving past the limit
        if (!sym) zero_cnt = zero_cnt + 16'd1;
        tot17 = {1'b0, total_cnt} + 17'd1;
        if (tot17 > {1'b0, rescale_limit}) begin
            zero_cnt = zero_cnt >> 1;
            tot17    = tot17 >> 1;
            if (zero_cnt == 0) zero_cnt = 16'd1;
            if ({1'b0, zero_cnt} >= tot17) tot17 = {1'b0, zero_cnt} + 17'd1;
        end
        total_cnt = tot17[CNT_W-1:0];

        if (eos) begin
            lo = hi;
            renorm();
            while (fill != 0) pack_bit(1'b0);
            lo = '0;
            hi = RANGE_TOP;
            pend = '0;
            stream_idle = 1'b1;
        end
        if (fresh_q.size() > 0) begin
            fresh_q[$].run_last    = 1'b1;
            fresh_q[$].stream_last = eos;
        end
        foreach (fresh_q[k]) code_q.push_back(fresh_q[k]);
    endfunction

    always @(posedge i_clk) begin
        t_code_out exp_c;
        if (!i_rst_n) begin
            rescale_limit = RESCALE_LIMIT_RST;
            init_zero     = INIT_ZERO_RST;
            init_total    = INIT_TOTAL_RST;
            lo = '0;
            hi = RANGE_TOP;
            pend = '0;
            zero_cnt  = INIT_ZERO_RST;
            total_cnt = INIT_TOTAL_RST;
            pack = '0;
            fill = '0;
            stream_idle = 1'b1;
            code_q.delete();
            errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RESCALE_LIMIT: rescale_limit = i_cfg_data;
                    CFG_INIT_ZERO:     init_zero     = i_cfg_data;
                    CFG_INIT_TOTAL:    init_total    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (code_q.size() == 0) begin
                    $error("unexpected output byte %0h", i_code_byte);
                    errors++;
                end else begin
                    exp_c = code_q.pop_front();
                    if (exp_c.code_byte != i_code_byte) begin
                        $error("code_byte: expected %0h, actual %0h",
                               exp_c.code_byte, i_code_byte);
                        errors++;
                    end
                    if (exp_c.run_last != i_run_last) begin
                        $error("run_last: expected %0d, actual %0d",
                               exp_c.run_last, i_run_last);
                        errors++;
                    end
                    if (exp_c.stream_last != i_stream_last) begin
                        $error("stream_last: expected %0d, actual %0d",
                               exp_c.stream_last, i_stream_last);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) encode_symbol(i_symbol, i_end_of_stream);
        end
    end
endmodule

[tb/adaptive_binary_arith_encoder_top_tb.sv]
// Testbench top for the adaptive binary arithmetic encoder: stimulus and verdict.
module adaptive_binary_arith_encoder_top_tb
    import abae_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 1000;  // covers a flush plus dropped bytes
    localparam int PHASE_ITEMS  = 44;
    localparam int N_PHASES     = 6;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 i_symbol = 1'b0;
    logic                 i_end_of_stream = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_RESCALE_LIMIT;
    logic [CNT_W-1:0]     i_cfg_data = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [7:0]           o_code_byte;
    logic                 o_run_last;
    logic                 o_stream_last;
    int                   errors;
    int                   outstanding;

    // idle percentages of the two sides, changed per phase
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;

    adaptive_binary_arith_encoder_top uut (.*);

    abae_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_in_stall(o_in_stall), .i_symbol, .i_end_of_stream,
        .i_out_valid(o_out_valid), .i_out_stall, .i_code_byte(o_code_byte),
        .i_run_last(o_run_last), .i_stream_last(o_stream_last),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_outstanding(outstanding)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver backpressure, re-rolled every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

    // One symbol transaction. Called right after a posedge; valid is left high
    // on return so back-to-back transactions need no extra cycle.
    task automatic send_symbol(logic sym, logic eos);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_symbol        <= sym;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    // Sender stops until every predicted byte has been taken, then lets the
    // block finish any trailing work before the next register write.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Streams of random length with a per-stream symbol bias, closed by an
    // end_of_stream; now and then a burst of fully random noise.
    task automatic random_items(int count);
        int left, len, bias;
        bit noisy;
        left = count;
        while (left > 0) begin
            len   = $urandom_range(1, 40);
            if (len > left) len = left;
            bias  = $urandom_range(0, 100);
            noisy = ($urandom_range(9) == 0);
            for (int k = 0; k < len; k++) begin
                if (noisy) send_symbol(1'($urandom_range(1)), $urandom_range(3) == 0);
                else send_symbol($urandom_range(99) < bias, k == len - 1);
            end
            left -= len;
        end
    endtask

    // register settings per phase: rescale limit, initial zero, initial total
    logic [CNT_W-1:0] cfg_sets[N_PHASES][3] = '{
        '{16'd20,    16'd1,     16'd11},     // reset values written back
        '{16'd2,     16'd1,     16'd2},      // smallest legal settings
        '{16'd0,     16'd0,     16'd0},      // zero counts fixed up, rescale always
        '{16'hffff,  16'hfffe,  16'hffff},   // top of range, total passes the limit to rescale
        '{16'hffff,  16'hffff,  16'd100},    // zero count clamped
        '{16'd1,     16'd300,   16'd7}       // total below zero count
    };

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with reset settings, no idling
        send_symbol(1'b0, 1'b0);
        send_symbol(1'b1, 1'b0);
        send_symbol(1'b0, 1'b1);       // short stream flushed
        send_symbol(1'b1, 1'b1);       // one-symbol stream
        for (int k = 0; k < 12; k++) send_symbol(1'b1, k == 11);  // likely symbol run
        for (int k = 0; k < 8; k++) send_symbol(1'b0, k == 7);    // unlikely symbol run
        drain_block();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // idling: sender light / receiver heavy, then swapped, then none
            case (ph / 2)
                0: begin sender_idle_pct = 13; receiver_stall_pct = 81; end
                1: begin sender_idle_pct = 81; receiver_stall_pct = 13; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            write_reg(CFG_RESCALE_LIMIT, cfg_sets[ph][0]);
            write_reg(CFG_INIT_ZERO,     cfg_sets[ph][1]);
            write_reg(CFG_INIT_TOTAL,    cfg_sets[ph][2]);
            random_items(PHASE_ITEMS);
            drain_block();
        end

        if (errors == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
